@@ sv/bfs_pkg.sv @@
package bfs_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 3;

    // command codes carried on s_axis_tuser
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // result status codes carried on m_axis_tuser
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY = 2'd2;

    localparam logic [POS_W-1:0] MSB_IDX = 3'd7;
    localparam logic [POS_W-1:0] LSB_IDX = 3'd0;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] data;
    } t_cell_ctrl;

endpackage

@@ sv/bfs_cell.sv @@
module bfs_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bfs_pkg::t_cell_ctrl      i_ctrl,
    input  logic                     i_prev_valid,
    input  logic                     i_next_valid,
    input  logic [bfs_pkg::BYTE_W-1:0] i_next_byte,
    output logic                     o_valid,
    output logic [bfs_pkg::BYTE_W-1:0] o_byte
);

    logic                       r_valid;
    logic [bfs_pkg::BYTE_W-1:0] r_byte;
    logic                       n_valid;
    logic [bfs_pkg::BYTE_W-1:0] n_byte;

    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        if (i_ctrl.pop) begin
            // the whole chain moves one place towards the head
            n_valid = i_next_valid;
            n_byte  = i_next_byte;
        end else if (i_ctrl.push && !r_valid && i_prev_valid) begin
            // first free cell takes the new byte
            n_valid = 1'b1;
            n_byte  = i_ctrl.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

@@ sv/byte_fifo_bit_serializer.sv @@
// Byte queue read out bit by bit, most significant bit first. A transaction on
// s_axis with tuser 0 pushes the byte in tdata, with tuser 1 pops the next bit
// of the oldest byte; after bit 0 that byte leaves the queue. Every input
// transaction yields exactly one result on m_axis, in the cycle after
// acceptance, carrying a status (done, push refused full, pop refused empty),
// the popped bit and whether the queue is empty afterwards. One transaction is
// taken in every cycle while the output register is free or being drained; the
// store is a chain of DEPTH byte cells that shifts towards the head when a byte
// is dropped.
module byte_fifo_bit_serializer #(
    parameter int DEPTH = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] cmd
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] bit_out, [1] empty_now, [7:2] zero
    output logic [1:0] m_axis_tuser    // [1:0] status
);

    logic [DEPTH-1:0]           w_valid;
    logic [bfs_pkg::BYTE_W-1:0] w_byte [DEPTH];
    bfs_pkg::t_cell_ctrl        w_ctrl;

    logic [bfs_pkg::POS_W-1:0]  r_bit_pos;
    logic [bfs_pkg::POS_W-1:0]  n_bit_pos;
    logic                       r_out_valid;
    logic [1:0]                 r_status;
    logic                       r_bit;
    logic                       r_empty;
    logic [1:0]                 n_status;
    logic                       n_bit;
    logic                       n_empty;

    logic w_accept;
    logic w_is_pop;
    logic w_full;
    logic w_empty;
    logic w_push_ok;
    logic w_pop_ok;
    logic w_drop;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                       w_prev_valid;
            logic                       w_next_valid;
            logic [bfs_pkg::BYTE_W-1:0] w_next_byte;

            if (g == 0) begin : g_head
                assign w_prev_valid = 1'b1;
            end else begin : g_mid
                assign w_prev_valid = w_valid[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_next_valid = 1'b0;
                assign w_next_byte  = '0;
            end else begin : g_body
                assign w_next_valid = w_valid[g+1];
                assign w_next_byte  = w_byte[g+1];
            end

            bfs_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_prev_valid (w_prev_valid),
                .i_next_valid (w_next_valid),
                .i_next_byte  (w_next_byte),
                .o_valid      (w_valid[g]),
                .o_byte       (w_byte[g])
            );
        end
    endgenerate

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_is_pop      = (s_axis_tuser == bfs_pkg::CMD_POP);
    assign w_full        = w_valid[DEPTH-1];
    assign w_empty       = !w_valid[0];
    assign w_push_ok     = w_accept && !w_is_pop && !w_full;
    assign w_pop_ok      = w_accept && w_is_pop && !w_empty;
    assign w_drop        = w_pop_ok && (r_bit_pos == bfs_pkg::LSB_IDX);

    assign w_ctrl.push = w_push_ok;
    assign w_ctrl.pop  = w_drop;
    assign w_ctrl.data = s_axis_tdata;

    always_comb begin
        n_bit_pos = r_bit_pos;
        if (w_pop_ok) begin
            n_bit_pos = w_drop ? bfs_pkg::MSB_IDX : r_bit_pos - 1'b1;
        end

        n_status = bfs_pkg::ST_DONE;
        if (w_is_pop && w_empty) begin
            n_status = bfs_pkg::ST_POP_EMPTY;
        end else if (!w_is_pop && w_full) begin
            n_status = bfs_pkg::ST_FULL;
        end

        n_bit = w_pop_ok ? w_byte[0][r_bit_pos] : 1'b0;

        // emptiness as it stands after this transaction
        if (w_push_ok) begin
            n_empty = 1'b0;
        end else if (w_drop) begin
            n_empty = !w_valid[1];
        end else begin
            n_empty = w_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_pos   <= bfs_pkg::MSB_IDX;
            r_out_valid <= 1'b0;
        end else begin
            r_bit_pos <= n_bit_pos;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_bit    <= n_bit;
            r_empty  <= n_empty;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {6'd0, r_empty, r_bit};

`ifndef SYNTHESIS
    // occupied cells always form a run starting at the head
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + 1'b1) & w_valid) == '0)
        else $error("occupied cells are not contiguous from the head");

    a_drop_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drop |=> r_bit_pos == bfs_pkg::MSB_IDX)
        else $error("bit position not back at msb after dropping a byte");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_pop && w_empty)
        |=> (r_out_valid && r_status == bfs_pkg::ST_POP_EMPTY && r_empty && !r_bit))
        else $error("pop on empty queue not reported as refused");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_ok |=> (w_valid[0] && !r_empty && r_status == bfs_pkg::ST_DONE))
        else $error("accepted push did not leave a byte in the queue");
`endif

endmodule
